FILE: design/ifa_pkg.sv
// Shared types, constants and helpers of the integer to ASCII formatter.
`default_nettype none

package ifa_pkg;

  // Word and buffer geometry
  localparam int WordBits   = 64;
  localparam int BufDepth   = 4096;
  localparam int PosW       = $clog2(BufDepth);
  localparam int IdxW       = 32;
  localparam int DigitSlots = 32;

  // Decimal digits of a full word, and the digit shift register width
  localparam int DecDigits  = 20;
  localparam int DigW       = DecDigits * 4;
  localparam int CntW       = $clog2(DecDigits + 1);
  localparam int PadW       = 5;
  localparam int HexDigits  = WordBits / 4;

  // Bit counter of the binary to BCD converter
  localparam int BitCntW    = $clog2(WordBits);

  // Stream widths
  localparam int InDataW    = 72;
  localparam int OutDataW   = 24;
  localparam int ReqW       = 3;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    ReqUdec = 3'd0,
    ReqSdec = 3'd1,
    ReqHexT = 3'd2,
    ReqHexF = 3'd3,
    ReqHexB = 3'd4,
    ReqChar = 3'd5,
    ReqClr  = 3'd6
  } req_e;

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;

  // Nibble to lower-case hex character
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ChZero + {4'b0, nib};
    end else begin
      ch = ChLowA + {4'b0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: design/ifa_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`default_nettype none

module ifa_dabble (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ifa_pkg::WordBits-1:0]  bin_i,
  output logic                               done_o,
  output logic [ifa_pkg::DigW-1:0]           bcd_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ifa_pkg::BitCntW-1:0]   cnt_q, cnt_d;
  logic [ifa_pkg::WordBits-1:0]  bin_q, bin_d;
  logic [ifa_pkg::DigW-1:0]      bcd_q, bcd_d;
  logic [ifa_pkg::DigW-1:0]      adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < ifa_pkg::DecDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Sequencing: load on start, then shift one bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ifa_pkg::BitCntW'(ifa_pkg::WordBits - 1);
      bin_d  = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[ifa_pkg::DigW-2:0], bin_q[ifa_pkg::WordBits-1]};
      bin_d = {bin_q[ifa_pkg::WordBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

FILE: design/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: request sequencer and character output.
//
// Usage: one request item enters on the s_axis channel (tuser = request code,
// tdata = value and pad width). The block answers with one m_axis item per
// character, most significant first, each carrying the buffer slot, a kept
// flag (tuser) and tlast on the final character of the request.
// s_axis_tready is high only while no request is in progress.
// Decimal requests run a bit-serial binary to BCD converter, then drop
// leading zero digits at one per cycle (keeping at least one digit), then
// send sign, padding and digits at one character per cycle while the
// receiver does not stall. Trimmed hex skips the conversion but trims leading
// zero nibbles one per cycle. Full hex, hex byte and raw character requests
// go straight to sending. A clear request or an unused code sends nothing.
// A one-entry output register sits on m_axis; while the receiver stalls the
// sequencer holds and nothing is lost. Reset empties the output, returns the
// sequencer to idle, clears the write index and selects wrap mode.
// cfg_we_i/cfg_wdata_i write the truncate mode bit (1 = drop when full).
`default_nettype none

module integer_to_ascii_formatter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: truncate mode
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  // Requests
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ifa_pkg::InDataW-1:0]   s_axis_tdata,  // value[63:0], pad_width[68:64]
  input  wire logic [ifa_pkg::ReqW-1:0]      s_axis_tuser,  // req_type[2:0]
  // Characters
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [ifa_pkg::OutDataW-1:0]       m_axis_tdata,  // out_char[7:0], buffer_pos[19:8]
  output logic                               m_axis_tuser,  // kept[0]
  output logic                               m_axis_tlast   // last
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StConv  = 7'b0000010,
    StTrim  = 7'b0000100,
    StSign  = 7'b0001000,
    StPad   = 7'b0010000,
    StDigit = 7'b0100000,
    StChar  = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [ifa_pkg::DigW-1:0]        dig_q, dig_d;
  logic [ifa_pkg::CntW-1:0]        n_q, n_d;
  logic [ifa_pkg::PadW-1:0]        pad_q, pad_d;
  logic [ifa_pkg::PadW-1:0]        padcnt_q, padcnt_d;
  logic                            neg_q, neg_d;
  logic                            dec_q, dec_d;
  logic [7:0]                      chr_q, chr_d;
  logic [ifa_pkg::IdxW-1:0]        wi_q, wi_d;
  logic                            trunc_q;

  logic                            ovalid_q, ovalid_d;
  logic [7:0]                      ochar_q, ochar_d;
  logic [ifa_pkg::PosW-1:0]        opos_q, opos_d;
  logic                            okept_q, okept_d;
  logic                            olast_q, olast_d;

  logic                            accept;
  logic [ifa_pkg::WordBits-1:0]    in_value;
  logic [ifa_pkg::PadW-1:0]        in_pad;
  ifa_pkg::req_e                   in_req;
  logic                            conv_start;
  logic [ifa_pkg::WordBits-1:0]    conv_bin;
  logic                            conv_done;
  logic [ifa_pkg::DigW-1:0]        conv_bcd;

  logic                            emit_req;
  logic                            fire;
  logic [7:0]                      emit_char;
  logic                            emit_last;
  logic [3:0]                      top_nib;
  logic                            pad_ok;
  logic [ifa_pkg::PadW-1:0]        pad_need;

  assign in_value = s_axis_tdata[ifa_pkg::WordBits-1:0];
  assign in_pad   = s_axis_tdata[ifa_pkg::WordBits +: ifa_pkg::PadW];
  assign in_req   = ifa_pkg::req_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  ifa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (conv_bin),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // Magnitude for decimal requests
  always_comb begin
    conv_bin = in_value;
    if (in_req == ifa_pkg::ReqSdec && in_value[ifa_pkg::WordBits-1]) begin
      conv_bin = ~in_value + 1'b1;
    end
  end
  assign conv_start = accept && (in_req == ifa_pkg::ReqUdec || in_req == ifa_pkg::ReqSdec);

  // Character selection for the current state
  assign top_nib = dig_q[ifa_pkg::DigW-1 -: 4];
  always_comb begin
    emit_req  = 1'b0;
    emit_char = ifa_pkg::hex_char(top_nib);
    emit_last = 1'b0;
    unique case (state_q)
      StSign: begin
        emit_req  = 1'b1;
        emit_char = ifa_pkg::ChMinus;
      end
      StPad: begin
        emit_req  = 1'b1;
        emit_char = ifa_pkg::ChZero;
      end
      StDigit: begin
        emit_req  = 1'b1;
        emit_last = (n_q == ifa_pkg::CntW'(1));
      end
      StChar: begin
        emit_req  = 1'b1;
        emit_char = chr_q;
        emit_last = 1'b1;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign fire = emit_req && (!ovalid_q || m_axis_tready);

  // Zero padding needed in front of the digits
  assign pad_ok   = dec_q && (pad_q != '0) && (6'(pad_q) < 6'(ifa_pkg::DigitSlots))
                    && (pad_q > ifa_pkg::PadW'(n_q));
  assign pad_need = pad_q - ifa_pkg::PadW'(n_q);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    dig_d    = dig_q;
    n_d      = n_q;
    pad_d    = pad_q;
    padcnt_d = padcnt_q;
    neg_d    = neg_q;
    dec_d    = dec_q;
    chr_d    = chr_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          pad_d = in_pad;
          neg_d = 1'b0;
          dec_d = 1'b0;
          unique case (in_req)
            ifa_pkg::ReqUdec: begin
              dec_d   = 1'b1;
              state_d = StConv;
            end
            ifa_pkg::ReqSdec: begin
              dec_d   = 1'b1;
              neg_d   = in_value[ifa_pkg::WordBits-1];
              state_d = StConv;
            end
            ifa_pkg::ReqHexT: begin
              dig_d   = {in_value, {(ifa_pkg::DigW - ifa_pkg::WordBits){1'b0}}};
              n_d     = ifa_pkg::CntW'(ifa_pkg::HexDigits);
              state_d = StTrim;
            end
            ifa_pkg::ReqHexF: begin
              dig_d   = {in_value, {(ifa_pkg::DigW - ifa_pkg::WordBits){1'b0}}};
              n_d     = ifa_pkg::CntW'(ifa_pkg::HexDigits);
              state_d = StDigit;
            end
            ifa_pkg::ReqHexB: begin
              dig_d   = {in_value[7:0], {(ifa_pkg::DigW - 8){1'b0}}};
              n_d     = ifa_pkg::CntW'(2);
              state_d = StDigit;
            end
            ifa_pkg::ReqChar: begin
              chr_d   = in_value[7:0];
              state_d = StChar;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StConv: begin
        if (conv_done) begin
          dig_d   = conv_bcd;
          n_d     = ifa_pkg::CntW'(ifa_pkg::DecDigits);
          state_d = StTrim;
        end
      end
      StTrim: begin
        if (top_nib == 4'd0 && n_q > ifa_pkg::CntW'(1)) begin
          dig_d = {dig_q[ifa_pkg::DigW-5:0], 4'd0};
          n_d   = n_q - 1'b1;
        end else begin
          padcnt_d = pad_ok ? pad_need : '0;
          priority if (neg_q) begin
            state_d = StSign;
          end else if (pad_ok) begin
            state_d = StPad;
          end else begin
            state_d = StDigit;
          end
        end
      end
      StSign: begin
        if (fire) begin
          state_d = (padcnt_q != '0) ? StPad : StDigit;
        end
      end
      StPad: begin
        if (fire) begin
          padcnt_d = padcnt_q - 1'b1;
          if (padcnt_q == ifa_pkg::PadW'(1)) begin
            state_d = StDigit;
          end
        end
      end
      StDigit: begin
        if (fire) begin
          dig_d = {dig_q[ifa_pkg::DigW-5:0], 4'd0};
          n_d   = n_q - 1'b1;
          if (n_q == ifa_pkg::CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      StChar: begin
        if (fire) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Write index and output register
  always_comb begin
    wi_d     = wi_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    opos_d   = opos_q;
    okept_d  = okept_q;
    olast_d  = olast_q;
    if (accept && in_req == ifa_pkg::ReqClr) begin
      wi_d = '0;
    end
    if (fire) begin
      ovalid_d = 1'b1;
      ochar_d  = emit_char;
      olast_d  = emit_last;
      if (trunc_q && wi_q >= ifa_pkg::IdxW'(ifa_pkg::BufDepth)) begin
        opos_d  = '0;
        okept_d = 1'b0;
      end else begin
        opos_d  = wi_q[ifa_pkg::PosW-1:0];
        okept_d = 1'b1;
        wi_d    = wi_q + 1'b1;
      end
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wi_q     <= '0;
      trunc_q  <= 1'b0;
      ovalid_q <= 1'b0;
      n_q      <= '0;
      padcnt_q <= '0;
      neg_q    <= 1'b0;
      dec_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      wi_q     <= wi_d;
      ovalid_q <= ovalid_d;
      n_q      <= n_d;
      padcnt_q <= padcnt_d;
      neg_q    <= neg_d;
      dec_q    <= dec_d;
      if (cfg_we_i) begin
        trunc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    pad_q   <= pad_d;
    chr_q   <= chr_d;
    ochar_q <= ochar_d;
    opos_q  <= opos_d;
    okept_q <= okept_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(ifa_pkg::OutDataW - ifa_pkg::PosW - 8){1'b0}}, opos_q, ochar_q};
  assign m_axis_tuser  = okept_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire
